### rtl/core/hkvs_pkg.sv
`default_nettype none

package hkvs_pkg;

  // Table geometry. BUCKETS is a power of two, so the non-negative remainder
  // of a two's complement key is its low bits.
  localparam int unsigned BUCKETS  = 64;
  localparam int unsigned WAYS     = 4;
  localparam int unsigned BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned ENTRY_W  = KEY_W + VALUE_W;
  localparam int unsigned ROW_W    = WAYS * ENTRY_W;

  // Request kinds; the fourth code is ignored.
  localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [VALUE_W-1:0] VALUE_ABSENT = '1;

  typedef struct packed {
    logic accept;  // capture request, issue bucket row read
    logic commit;  // compare ways, write row back, load result
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/hkvs_ram.sv
`default_nettype none

module hkvs_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 16
) (
  input  wire                                      clk_i,
  input  wire                                      we_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire  [DATA_W-1:0]                        wdata_i,
  input  wire                                      re_i,
  input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [DATA_W-1:0]                        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hkvs_ctrl.sv
`default_nettype none

module hkvs_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output hkvs_pkg::cmd_t  cmd_o
);

  import hkvs_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take a new word
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hkvs_dp.sv
`default_nettype none

module hkvs_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  hkvs_pkg::cmd_t                    cmd_i,
  input  wire  [hkvs_pkg::ACTION_W-1:0]     req_action_i,
  input  wire  [hkvs_pkg::KEY_W-1:0]        req_key_i,
  input  wire  [hkvs_pkg::VALUE_W-1:0]      req_value_i,
  output logic [hkvs_pkg::VALUE_W-1:0]      res_read_value_o,
  output logic                              res_found_o,
  output logic                              res_status_o
);

  import hkvs_pkg::*;

  logic [ACTION_W-1:0] action_q;
  logic [KEY_W-1:0]    key_q;
  logic [VALUE_W-1:0]  value_q;
  logic [BUCKET_W-1:0] bucket_q;

  logic [WAYS-1:0]     valid_q [BUCKETS];
  logic [WAYS-1:0]     valid_row;
  logic [WAYS-1:0]     valid_row_d;

  logic [ROW_W-1:0]    row_rd;
  logic [ROW_W-1:0]    row_wr;
  logic                row_we;

  logic [WAYS-1:0]     hit_oh;
  logic [WAYS-1:0]     free_oh;
  logic                any_hit;
  logic                any_free;
  logic [VALUE_W-1:0]  hit_value;

  logic                is_put;
  logic                is_get;
  logic                is_remove;

  logic [VALUE_W-1:0]  read_value_d;
  logic                found_d;
  logic                status_d;

  // Request registers; payload only, no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= req_action_i;
      key_q    <= req_key_i;
      value_q  <= req_value_i;
      bucket_q <= req_key_i[BUCKET_W-1:0];
    end
  end

  hkvs_ram #(
    .DATA_W (ROW_W),
    .DEPTH  (BUCKETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (bucket_q),
    .wdata_i (row_wr),
    .re_i    (cmd_i.accept),
    .raddr_i (req_key_i[BUCKET_W-1:0]),
    .rdata_o (row_rd)
  );

  assign valid_row = valid_q[bucket_q];
  assign is_put    = (action_q == ACT_PUT);
  assign is_get    = (action_q == ACT_GET);
  assign is_remove = (action_q == ACT_REMOVE);

  // Way match, value select and lowest free way.
  always_comb begin
    logic seen_free;
    hit_value = '0;
    seen_free = 1'b0;
    for (int w = 0; w < WAYS; w++) begin
      hit_oh[w]  = valid_row[w] && (row_rd[w*ENTRY_W +: KEY_W] == key_q);
      free_oh[w] = !valid_row[w] && !seen_free;
      seen_free  = seen_free || !valid_row[w];
      hit_value  = hit_value |
                   (row_rd[w*ENTRY_W+KEY_W +: VALUE_W] & {VALUE_W{hit_oh[w]}});
    end
    any_hit  = |hit_oh;
    any_free = seen_free;
  end

  // Row and valid bits after the request.
  always_comb begin
    row_wr      = row_rd;
    valid_row_d = valid_row;
    for (int w = 0; w < WAYS; w++) begin
      if (is_put && hit_oh[w]) begin
        row_wr[w*ENTRY_W+KEY_W +: VALUE_W] = value_q;
      end
      if (is_put && !any_hit && free_oh[w]) begin
        row_wr[w*ENTRY_W +: KEY_W]         = key_q;
        row_wr[w*ENTRY_W+KEY_W +: VALUE_W] = value_q;
        valid_row_d[w]                     = 1'b1;
      end
      if (is_remove && hit_oh[w]) begin
        valid_row_d[w] = 1'b0;
      end
    end
    row_we = cmd_i.commit && is_put && (any_hit || any_free);
  end

  always_comb begin
    read_value_d = (is_get && any_hit) ? hit_value : VALUE_ABSENT;
    found_d      = (is_put || is_get || is_remove) && any_hit;
    status_d     = is_put && !any_hit && !any_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < BUCKETS; b++) begin
        valid_q[b] <= '0;
      end
    end else if (cmd_i.commit) begin
      valid_q[bucket_q] <= valid_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_read_value_o <= read_value_d;
      res_found_o      <= found_d;
      res_status_o     <= status_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hashed_key_value_store_core.sv
`default_nettype none
// A request is accepted in idle, which registers it and issues the bucket row RAM
// read; the way compare, row and valid-bit write-back and result load follow in the
// execute state, and no new request is taken until that commit.
// A result waiting on the output holds back only the compare step.
// Reset (rst_ni low, asynchronous) empties every bucket and clears control.

module hashed_key_value_store_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // request stream
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [63:0] s_axis_tdata_i,   // [31:0] key, [63:32] value
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o    // [31:0] read_value, [32] found,
                                        // [33] status, [39:34] zero
);

  import hkvs_pkg::*;

  cmd_t               cmd;
  logic [VALUE_W-1:0] res_read_value;
  logic               res_found;
  logic               res_status;

  // Controller: accepts a word in idle, then commits it once the result
  // register is free (empty or being drained in the same cycle).
  hkvs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // Datapath: request registers, bucket row RAM, per-bucket valid bits,
  // way compare and the result register.
  hkvs_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .req_action_i     (s_axis_tuser_i),
    .req_key_i        (s_axis_tdata_i[31:0]),
    .req_value_i      (s_axis_tdata_i[63:32]),
    .res_read_value_o (res_read_value),
    .res_found_o      (res_found),
    .res_status_o     (res_status)
  );

  // Pack the result word, zero-fill to a whole byte.
  assign m_axis_tdata_o = {6'b0, res_status, res_found, res_read_value};

endmodule

`default_nettype wire

### tb/hashed_key_value_store_core_tb.sv
`timescale 1ns / 100ps

module hashed_key_value_store_core_tb;
  import hkvs_pkg::*;

  // Code for the one action that the core ignores.
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned SLOTS       = BUCKETS * WAYS;
  localparam int unsigned MAX_GAP     = 12;
  localparam int unsigned HOLD_CYCLES = 200;
  // Abort limit on the cycle count of the whole run, well above what the tests need.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 940;
  localparam int unsigned BURST_WORDS  = 40;

  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;

  typedef logic [$clog2(SLOTS)-1:0] slot_t;

  typedef struct {
    logic [VALUE_W-1:0] read_value;
    logic               found;
    logic               status;
  } lookup_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;   // [31:0] key, [63:32] value
  logic [1:0]  s_axis_tuser_i = '0;   // [1:0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] read_value, [32] found, [33] status

  hashed_key_value_store_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Shadow copy of the table, kept in step with every accepted request.
  bit                 shadow_valid [SLOTS];
  logic [KEY_W-1:0]   shadow_key   [SLOTS];
  logic [VALUE_W-1:0] shadow_value [SLOTS];

  lookup_result_t pending_results[$];

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  // Zero the idle gaps on both sides while set.
  bit          quiet          = 1'b0;
  // Ask the result side to hold off for a long stretch.
  bit          hold_req       = 1'b0;

  always #6 clk_i = ~clk_i;

  // Abort a run that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Non-negative remainder of the signed key.
  function automatic int bucket_of_key(input logic [KEY_W-1:0] key);
    longint k;
    longint r;
    k = longint'($signed(key));
    r = k % longint'(BUCKETS);
    if (r < 0) r = r + longint'(BUCKETS);
    return int'(r);
  endfunction

  // Apply one request to the shadow table and return the result word it causes.
  function automatic lookup_result_t apply_request(input logic [ACTION_W-1:0] action,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VALUE_W-1:0] value);
    lookup_result_t r;
    slot_t base;
    slot_t slot;
    slot_t hit_slot;
    bit    hit;
    r.read_value = VALUE_ABSENT;
    r.found      = 1'b0;
    r.status     = 1'b0;
    base     = slot_t'(bucket_of_key(key) * WAYS);
    hit      = 1'b0;
    hit_slot = base;
    for (int w = 0; w < WAYS; w++) begin
      slot = base + slot_t'(w);
      if (!hit && shadow_valid[slot] && shadow_key[slot] == key) begin
        hit      = 1'b1;
        hit_slot = slot;
      end
    end
    case (action)
      ACT_PUT: begin
        if (hit) begin
          r.found = 1'b1;
          shadow_value[hit_slot] = value;
        end else begin
          // Take the lowest free way; flag the drop when the bucket is full.
          r.status = 1'b1;
          for (int w = 0; w < WAYS; w++) begin
            slot = base + slot_t'(w);
            if (r.status && !shadow_valid[slot]) begin
              shadow_valid[slot] = 1'b1;
              shadow_key[slot]   = key;
              shadow_value[slot] = value;
              r.status = 1'b0;
            end
          end
        end
      end
      ACT_GET: begin
        if (hit) begin
          r.found      = 1'b1;
          r.read_value = shadow_value[hit_slot];
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          r.found = 1'b1;
          shadow_valid[hit_slot] = 1'b0;
        end
      end
      default: begin
        // Unused code: leave the table alone.
      end
    endcase
    return r;
  endfunction

  // Offer one request word after a random gap (none while quiet) and return at the edge that takes it.
  // Keep tvalid high across back-to-back words; lower it only for a real gap.
  task automatic send_request(input logic [ACTION_W-1:0] action,
                              input logic [KEY_W-1:0] key,
                              input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {value, key};
    s_axis_tuser_i  <= action;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(apply_request(action, key, value));
  endtask

  // Draw a request that mostly lands in a few crowded buckets so that
  // hits, overwrites and full buckets come up often.
  task automatic send_random_request();
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    int unsigned         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      action = ACT_PUT;
    else if (pick < 75) action = ACT_GET;
    else if (pick < 95) action = ACT_REMOVE;
    else                action = ACT_UNUSED;
    if ($urandom_range(0, 9) < 7) begin
      key = KEY_W'($urandom_range(0, 11) * BUCKETS + $urandom_range(0, 5));
      if ($urandom_range(0, 1)) key = -key;
    end else begin
      key = $urandom;
    end
    send_request(action, key, $urandom);
  endtask

  // Stop offering and hold until every expected word has come back, plus some margin.
  task automatic wait_for_drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Result side: stall a random number of cycles before each word, or hold off
  // for a long stretch when asked.
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready_i <= 1'b1;
        do @(posedge clk_i); while (!m_axis_tvalid_o && !hold_req);
      end
    end
  end

  // Check every result word against the oldest expectation.
  always @(posedge clk_i) begin
    lookup_result_t exp_r;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: tdata=%h", m_axis_tdata_o);
        mismatch_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tdata_o[31:0] !== exp_r.read_value) begin
          $error("read_value: expected %h, actual %h", exp_r.read_value,
                 m_axis_tdata_o[31:0]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[32] !== exp_r.found) begin
          $error("found: expected %b, actual %b", exp_r.found, m_axis_tdata_o[32]);
          mismatch_count++;
        end
        if (m_axis_tdata_o[33] !== exp_r.status) begin
          $error("status: expected %b, actual %b", exp_r.status, m_axis_tdata_o[33]);
          mismatch_count++;
        end
      end
    end
  end

  // Extreme keys and values, then an overwrite of a held key.
  task automatic test_extreme_keys();
    send_request(ACT_PUT, KEY_MIN, 32'h7fff_ffff);
    send_request(ACT_PUT, KEY_MAX, 32'h8000_0000);
    send_request(ACT_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(ACT_PUT, 32'hffff_ffff, 32'hffff_ffff);
    send_request(ACT_GET, KEY_MIN, 32'h0);
    send_request(ACT_GET, KEY_MAX, 32'h0);
    send_request(ACT_GET, 32'h0000_0000, 32'h0);
    send_request(ACT_GET, 32'hffff_ffff, 32'h0);
    send_request(ACT_PUT, KEY_MAX, 32'h1234_5678);
    send_request(ACT_GET, KEY_MAX, 32'hffff_ffff);
    wait_for_drain();
  endtask

  // Absent keys, the ignored action code, and removal of a held key.
  task automatic test_absent_and_unused();
    send_request(ACT_GET, 32'd5, 32'h0);
    send_request(ACT_REMOVE, 32'd5, 32'h0);
    send_request(ACT_UNUSED, KEY_MIN, 32'hdead_beef);
    send_request(ACT_GET, KEY_MIN, 32'h0);
    send_request(ACT_REMOVE, KEY_MIN, 32'h0);
    send_request(ACT_GET, KEY_MIN, 32'h0);
    wait_for_drain();
  endtask

  // Fill one bucket (a negative key shares it), drop a put, then free a way.
  task automatic test_bucket_overflow();
    send_request(ACT_PUT, 32'd7, 32'h0000_0007);
    send_request(ACT_PUT, 32'd71, 32'h0000_0047);
    send_request(ACT_PUT, 32'd135, 32'h0000_0087);
    send_request(ACT_PUT, -32'sd57, 32'hffff_ffc7);
    send_request(ACT_PUT, 32'd199, 32'h0000_00c7);
    send_request(ACT_REMOVE, 32'd71, 32'h0);
    send_request(ACT_PUT, 32'd199, 32'h0000_00c7);
    send_request(ACT_GET, 32'd199, 32'h0);
    wait_for_drain();
  endtask

  // Random traffic with random idling; some stretches run without gaps.
  task automatic test_random_traffic();
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_request();
    end
    quiet = 1'b0;
    wait_for_drain();
  endtask

  // Hold the result side off while requests keep coming, so the core fills
  // up and stalls its input.
  task automatic test_backpressure();
    quiet    = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < BURST_WORDS; i++) send_random_request();
    wait_for_drain();
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extreme_keys();
    test_absent_and_unused();
    test_bucket_overflow();
    test_random_traffic();
    test_backpressure();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
